@@ rtl/bb3_pkg.sv @@
// bb3_pkg: shared types, constants and the reciprocal table of the 3x3 box blur.
// No dependencies; imported by every module of the block but bb3_ram.
package bb3_pkg;

  localparam int FW_W   = 11;   // frame_width register
  localparam int FH_W   = 13;   // frame_height register
  localparam int CFG_W  = 13;   // write data, widest register
  localparam int CH_W   = 8;
  localparam int PIX_W  = 3 * CH_W;
  localparam int SUM_W  = 12;   // nine 8-bit terms plus rounding half
  localparam int CNT_W  = 4;    // neighbor count, up to nine
  localparam int RCP_W  = 17;
  localparam int RCP_SH = 16;

  localparam logic [FW_W-1:0] FRAME_WIDTH_RST  = 11'd1024;
  localparam logic [FH_W-1:0] FRAME_HEIGHT_RST = 13'd768;

  localparam logic [0:0] REG_FRAME_WIDTH  = 1'b0;
  localparam logic [0:0] REG_FRAME_HEIGHT = 1'b1;

  localparam logic OP_PIXEL = 1'b0;
  localparam logic OP_DRAIN = 1'b1;

  typedef logic [PIX_W-1:0] pix_t;
  // window indexed [row][col], row 0 oldest line, col 0 oldest column
  typedef pix_t [2:0][2:0] win_t;

  typedef struct packed {
    logic top;
    logic bottom;
    logic left;
    logic right;
    logic done;
  } nbr_t;

  typedef struct packed {
    logic fill;    // new word taken into the input stage
    logic shift;   // input stage moves into the window
  } win_ctl_t;

  typedef struct packed {
    logic sum_en;
    logic div_en;
  } mean_ctl_t;

  // ceil(2^16 / n), exact for dividends below 4096
  function automatic logic [RCP_W-1:0] recip(input logic [CNT_W-1:0] n);
    logic [RCP_W-1:0] r;
    case (n)
      4'd1:    r = 17'd65536;
      4'd2:    r = 17'd32768;
      4'd3:    r = 17'd21846;
      4'd4:    r = 17'd16384;
      4'd6:    r = 17'd10923;
      4'd9:    r = 17'd7282;
      default: r = 17'd65536;
    endcase
    return r;
  endfunction

endpackage

@@ rtl/box_blur_3x3_edge_aware.sv @@
// Edge-aware 3x3 box blur over a raster-order RGB pixel stream.
// Depends on bb3_pkg, bb3_window and bb3_mean.
//
// Input channel in_valid/in_ready carries op and in_red/in_green/in_blue;
// op marks a drain word with no pixel. Output channel out_valid/out_ready
// carries the rounded mean of each pixel's in-frame neighbors per color and
// frame_end on the frame's last pixel. frame_width/frame_height are written
// through wr_en/wr_index/wr_data; the user must do so only while the block
// is idle; the block does not enforce it. Each result belongs to the word
// frame_width+1 positions earlier; the final frame_width+1 results of a
// frame are pushed out by drain words. Throughput is one word per cycle
// unless stalled. A word that produces a result passes the input stage with
// the line store read, then window, channel sums, divide by neighbor count.
// Line stores are two RAMs of MAX_WIDTH entries, one read and one write each
// per cycle; a same-column write/read pair is forwarded.
// Synchronous reset empties the pipeline, zeroes the window and position
// counters and restores width 1024, height 768; line stores are not cleared.
// When out_ready is low the result holds and the stages behind it fill;
// in_ready drops only once every stage holds a word.
module box_blur_3x3_edge_aware #(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_HEIGHT = 4096
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic                       op,
  input  logic [bb3_pkg::CH_W-1:0]   in_red,
  input  logic [bb3_pkg::CH_W-1:0]   in_green,
  input  logic [bb3_pkg::CH_W-1:0]   in_blue,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [bb3_pkg::CH_W-1:0]   out_red,
  output logic [bb3_pkg::CH_W-1:0]   out_green,
  output logic [bb3_pkg::CH_W-1:0]   out_blue,
  output logic                       frame_end,
  input  logic                       wr_en,
  input  logic [0:0]                 wr_index,
  input  logic [bb3_pkg::CFG_W-1:0]  wr_data
);
  import bb3_pkg::*;

  localparam int COL_W = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int ROW_W = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;

  function automatic logic [FW_W-1:0] wlast_of(input logic [FW_W-1:0] v);
    logic [FW_W-1:0] r;
    if (v == '0) begin
      r = '0;
    end else if (32'(v) > 32'(MAX_WIDTH)) begin
      r = FW_W'(MAX_WIDTH - 1);
    end else begin
      r = v - 1'b1;
    end
    return r;
  endfunction

  function automatic logic [FH_W-1:0] hlast_of(input logic [FH_W-1:0] v);
    logic [FH_W-1:0] r;
    if (v == '0) begin
      r = '0;
    end else if (32'(v) > 32'(MAX_HEIGHT)) begin
      r = FH_W'(MAX_HEIGHT - 1);
    end else begin
      r = v - 1'b1;
    end
    return r;
  endfunction

  logic [FW_W-1:0]  w_last;
  logic [FH_W-1:0]  h_last;

  logic [COL_W-1:0] in_column;
  logic [1:0]       in_row;      // saturates at two
  logic [COL_W-1:0] out_column;
  logic [ROW_W-1:0] out_row;

  logic a_vld, b_vld, c_vld;
  logic a_emit;
  nbr_t a_nbr, b_nbr, nbr;
  logic a_go, b_go, c_go;
  logic a_free, b_free, c_free, d_free;
  logic in_fire;

  logic emit, col_last, ocol_last, orow_last;
  pix_t px;
  win_t win;
  win_ctl_t  wctl;
  mean_ctl_t mctl;

  // configuration, stored as clamped last index
  always_ff @(posedge clk) begin
    if (rst) begin
      w_last <= wlast_of(FRAME_WIDTH_RST);
      h_last <= hlast_of(FRAME_HEIGHT_RST);
    end else if (wr_en) begin
      case (wr_index)
        REG_FRAME_WIDTH:  w_last <= wlast_of(wr_data[FW_W-1:0]);
        REG_FRAME_HEIGHT: h_last <= hlast_of(wr_data[FH_W-1:0]);
        default: ;
      endcase
    end
  end

  // stage handshake
  assign d_free   = !out_valid || out_ready;
  assign c_go     = c_vld && d_free;
  assign c_free   = !c_vld || d_free;
  assign b_go     = b_vld && c_free;
  assign b_free   = !b_vld || c_free;
  assign a_go     = a_vld && b_free;
  assign a_free   = !a_vld || b_free;
  assign in_ready = a_free;
  assign in_fire  = in_valid && in_ready;

  // position bookkeeping for the word at the input
  assign col_last  = 32'(in_column) >= 32'(w_last);
  assign emit      = in_row[1] || (in_row[0] && (in_column != '0));
  assign ocol_last = 32'(out_column) >= 32'(w_last);
  assign orow_last = 32'(out_row) >= 32'(h_last);

  always_comb begin
    nbr.top    = out_row != '0;
    nbr.bottom = !orow_last;
    nbr.left   = out_column != '0;
    // at a row start the pending output is a row end: no right neighbor
    nbr.right  = !ocol_last && (in_column != '0);
    nbr.done   = orow_last && ocol_last;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_column  <= '0;
      in_row     <= '0;
      out_column <= '0;
      out_row    <= '0;
    end else if (in_fire) begin
      if (emit && nbr.done) begin
        in_column  <= '0;
        in_row     <= '0;
        out_column <= '0;
        out_row    <= '0;
      end else begin
        if (col_last) begin
          in_column <= '0;
          if (!in_row[1]) begin
            in_row <= in_row + 2'd1;
          end
        end else begin
          in_column <= in_column + 1'b1;
        end
        if (emit) begin
          if (ocol_last) begin
            out_column <= '0;
            out_row    <= out_row + 1'b1;
          end else begin
            out_column <= out_column + 1'b1;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      a_vld     <= 1'b0;
      b_vld     <= 1'b0;
      c_vld     <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (in_fire) begin
        a_vld <= 1'b1;
      end else if (a_go) begin
        a_vld <= 1'b0;
      end
      // words with no result only move the window
      if (a_go) begin
        b_vld <= a_emit;
      end else if (b_go) begin
        b_vld <= 1'b0;
      end
      if (b_go) begin
        c_vld <= 1'b1;
      end else if (c_go) begin
        c_vld <= 1'b0;
      end
      if (c_go) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      a_emit <= emit;
      a_nbr  <= nbr;
    end
    if (a_go) begin
      b_nbr <= a_nbr;
    end
  end

  assign px = (op == OP_DRAIN) ? '0 : {in_red, in_green, in_blue};

  assign wctl.fill  = in_fire;
  assign wctl.shift = a_go;

  bb3_window #(.MAX_WIDTH(MAX_WIDTH)) u_window (
    .clk (clk),
    .rst (rst),
    .ctl (wctl),
    .col (in_column),
    .px  (px),
    .win (win)
  );

  assign mctl.sum_en = b_go;
  assign mctl.div_en = c_go;

  bb3_mean u_mean (
    .clk       (clk),
    .ctl       (mctl),
    .win       (win),
    .nbr       (b_nbr),
    .out_red   (out_red),
    .out_green (out_green),
    .out_blue  (out_blue),
    .frame_end (frame_end)
  );

endmodule

@@ rtl/bb3_ram.sv @@
// bb3_ram: generic single-write, single-read RAM with registered read data.
// No dependencies.
module bb3_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 1024,
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WIDTH-1:0]  wdata,
  input  logic              re,
  input  logic [ADDR_W-1:0] raddr,
  output logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

@@ rtl/bb3_window.sv @@
// bb3_window: input stage, the two line stores and the 3x3 window registers.
// Depends on bb3_pkg and bb3_ram.
module bb3_window #(
  parameter int MAX_WIDTH = 1024,
  localparam int COL_W = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1
) (
  input  logic              clk,
  input  logic              rst,
  input  bb3_pkg::win_ctl_t ctl,
  input  logic [COL_W-1:0]  col,
  input  bb3_pkg::pix_t     px,
  output bb3_pkg::win_t     win
);
  import bb3_pkg::*;

  pix_t             a_px;
  logic [COL_W-1:0] a_col;
  logic             a_byp;
  pix_t             byp_lower;
  pix_t             byp_upper;
  pix_t             upper_q;
  pix_t             lower_q;
  pix_t             upper_eff;
  pix_t             lower_eff;

  // read issued on the same edge the previous word writes the same column
  always_ff @(posedge clk) begin
    if (ctl.fill) begin
      a_px      <= px;
      a_col     <= col;
      a_byp     <= ctl.shift && (col == a_col);
      byp_lower <= a_px;
      byp_upper <= lower_eff;
    end
  end

  assign lower_eff = a_byp ? byp_lower : lower_q;
  assign upper_eff = a_byp ? byp_upper : upper_q;

  bb3_ram #(.WIDTH(PIX_W), .DEPTH(MAX_WIDTH)) u_lower (
    .clk   (clk),
    .we    (ctl.shift),
    .waddr (a_col),
    .wdata (a_px),
    .re    (ctl.fill),
    .raddr (col),
    .rdata (lower_q)
  );

  bb3_ram #(.WIDTH(PIX_W), .DEPTH(MAX_WIDTH)) u_upper (
    .clk   (clk),
    .we    (ctl.shift),
    .waddr (a_col),
    .wdata (lower_eff),
    .re    (ctl.fill),
    .raddr (col),
    .rdata (upper_q)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      win <= '0;
    end else if (ctl.shift) begin
      for (int r = 0; r < 3; r++) begin
        win[r][0] <= win[r][1];
        win[r][1] <= win[r][2];
      end
      win[0][2] <= upper_eff;
      win[1][2] <= lower_eff;
      win[2][2] <= a_px;
    end
  end

endmodule

@@ rtl/bb3_mean.sv @@
// bb3_mean: masked 3x3 sum per channel, then rounded division by the count.
// Depends on bb3_pkg.
module bb3_mean (
  input  logic                      clk,
  input  bb3_pkg::mean_ctl_t        ctl,
  input  bb3_pkg::win_t             win,
  input  bb3_pkg::nbr_t             nbr,
  output logic [bb3_pkg::CH_W-1:0]  out_red,
  output logic [bb3_pkg::CH_W-1:0]  out_green,
  output logic [bb3_pkg::CH_W-1:0]  out_blue,
  output logic                      frame_end
);
  import bb3_pkg::*;

  localparam int PROD_W = SUM_W + RCP_W;

  logic [2:0]       row_en;
  logic [2:0]       col_en;
  logic [1:0]       n_rows;
  logic [1:0]       n_cols;
  logic [CNT_W-1:0] n;
  logic [SUM_W-1:0] sum [3];

  logic [SUM_W-1:0]  c_sum [3];
  logic [CNT_W-1:0]  c_n;
  logic              c_done;
  logic [PROD_W-1:0] prod [3];

  assign row_en = {nbr.bottom, 1'b1, nbr.top};
  assign col_en = {nbr.right, 1'b1, nbr.left};
  assign n_rows = 2'd1 + {1'b0, nbr.top} + {1'b0, nbr.bottom};
  assign n_cols = 2'd1 + {1'b0, nbr.left} + {1'b0, nbr.right};
  assign n      = CNT_W'(n_rows) * CNT_W'(n_cols);

  // lane 2 red, 1 green, 0 blue
  always_comb begin
    for (int ch = 0; ch < 3; ch++) begin
      sum[ch] = '0;
    end
    for (int r = 0; r < 3; r++) begin
      for (int k = 0; k < 3; k++) begin
        for (int ch = 0; ch < 3; ch++) begin
          if (row_en[r] && col_en[k]) begin
            sum[ch] = sum[ch] + SUM_W'(win[r][k][ch*CH_W +: CH_W]);
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.sum_en) begin
      for (int ch = 0; ch < 3; ch++) begin
        c_sum[ch] <= sum[ch] + SUM_W'(n >> 1);
      end
      c_n    <= n;
      c_done <= nbr.done;
    end
  end

  always_comb begin
    for (int ch = 0; ch < 3; ch++) begin
      prod[ch] = PROD_W'(c_sum[ch]) * PROD_W'(recip(c_n));
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.div_en) begin
      out_red   <= prod[2][RCP_SH +: CH_W];
      out_green <= prod[1][RCP_SH +: CH_W];
      out_blue  <= prod[0][RCP_SH +: CH_W];
      frame_end <= c_done;
    end
  end

endmodule

@@ rtl/bb3_checker.sv @@
// bb3_checker: port-level checks of the box blur, attached by bind.
// Depends on bb3_pkg and box_blur_3x3_edge_aware.
module bb3_checker (
  input logic                      clk,
  input logic                      rst,
  input logic                      in_valid,
  input logic                      in_ready,
  input logic                      out_valid,
  input logic                      out_ready,
  input logic [bb3_pkg::CH_W-1:0]  out_red,
  input logic [bb3_pkg::CH_W-1:0]  out_green,
  input logic [bb3_pkg::CH_W-1:0]  out_blue,
  input logic                      frame_end
);

  // a stalled result word stays put
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_red) &&
      $stable(out_green) && $stable(out_blue) && $stable(frame_end))
    else $error("stalled output word changed");

  // reset empties the output register
  a_rst_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("output valid right after reset");

  // backpressure reaches the input only through a held output word
  a_ready_free: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> in_ready)
    else $error("input stalled with empty output register");

  // with the output side ready, the input is never refused
  a_no_bubble: assert property (@(posedge clk) disable iff (rst)
    out_ready |-> in_ready)
    else $error("input stalled while output side is ready");

endmodule

bind box_blur_3x3_edge_aware bb3_checker u_bb3_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_red   (out_red),
  .out_green (out_green),
  .out_blue  (out_blue),
  .frame_end (frame_end)
);
